FILE: hw/rtl/ccs_pkg.sv
package ccs_pkg;

  // characters that steer the scanner
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChSquote  = 8'h27;
  localparam logic [7:0] ChNewline = 8'h0A;

  // result queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // number of words one input byte produces
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_ONE  = 2'd1,
    EMIT_TWO  = 2'd2
  } emit_t;

  // words handed from the scanner to the result queue
  typedef struct packed {
    emit_t      emit;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } push_t;

endpackage

FILE: hw/rtl/ccs_scan.sv
module ccs_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       cur_byte,
  output ccs_pkg::push_t   push
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4,
    MODE_LIT    = 3'd5
  } mode_t;

  mode_t mode;
  mode_t mode_next;
  logic  quote_kind;
  logic  quote_kind_next;

  always_comb begin
    mode_next       = mode;
    quote_kind_next = quote_kind;
    push.emit       = ccs_pkg::EMIT_NONE;
    push.byte0      = cur_byte;
    push.byte1      = cur_byte;
    unique case (mode)
      MODE_SLASH: begin
        if (cur_byte == ccs_pkg::ChSlash) begin
          mode_next = MODE_LINE;
        end else if (cur_byte == ccs_pkg::ChStar) begin
          mode_next = MODE_BLOCK;
        end else begin
          // release the held slash ahead of this byte
          push.emit  = ccs_pkg::EMIT_TWO;
          push.byte0 = ccs_pkg::ChSlash;
          if (cur_byte == ccs_pkg::ChDquote) begin
            mode_next       = MODE_LIT;
            quote_kind_next = 1'b0;
          end else if (cur_byte == ccs_pkg::ChSquote) begin
            mode_next       = MODE_LIT;
            quote_kind_next = 1'b1;
          end else begin
            mode_next = MODE_NORMAL;
          end
        end
      end
      MODE_LINE: begin
        if (cur_byte == ccs_pkg::ChNewline) begin
          push.emit = ccs_pkg::EMIT_ONE;
          mode_next = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (cur_byte == ccs_pkg::ChStar) begin
          mode_next = MODE_STAR;
        end else if (cur_byte == ccs_pkg::ChNewline) begin
          push.emit = ccs_pkg::EMIT_ONE;
        end
      end
      MODE_STAR: begin
        if (cur_byte == ccs_pkg::ChSlash) begin
          mode_next = MODE_NORMAL;
        end else if (cur_byte != ccs_pkg::ChStar) begin
          if (cur_byte == ccs_pkg::ChNewline) begin
            push.emit = ccs_pkg::EMIT_ONE;
          end
          mode_next = MODE_BLOCK;
        end
      end
      MODE_LIT: begin
        push.emit = ccs_pkg::EMIT_ONE;
        if (cur_byte == ccs_pkg::ChNewline ||
            (!quote_kind && cur_byte == ccs_pkg::ChDquote) ||
            (quote_kind && cur_byte == ccs_pkg::ChSquote)) begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        // normal mode, unused codes behave the same
        if (cur_byte == ccs_pkg::ChSlash) begin
          mode_next = MODE_SLASH;
        end else begin
          push.emit = ccs_pkg::EMIT_ONE;
          if (cur_byte == ccs_pkg::ChDquote) begin
            mode_next       = MODE_LIT;
            quote_kind_next = 1'b0;
          end else if (cur_byte == ccs_pkg::ChSquote) begin
            mode_next       = MODE_LIT;
            quote_kind_next = 1'b1;
          end else begin
            mode_next = MODE_NORMAL;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      quote_kind <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      quote_kind <= quote_kind_next;
    end
  end

`ifndef SYNTHESIS
  // two words only come from a released slash
  a_two_needs_slash: assert property (@(posedge clk) disable iff (rst)
    push.emit == ccs_pkg::EMIT_TWO |-> mode == MODE_SLASH && push.byte0 == ccs_pkg::ChSlash)
    else $error("double emit outside slash pending");
  // a literal only opens on a quote byte
  a_lit_entry: assert property (@(posedge clk) disable iff (rst)
    step && mode != MODE_LIT && mode_next == MODE_LIT |->
      cur_byte == ccs_pkg::ChDquote || cur_byte == ccs_pkg::ChSquote)
    else $error("literal opened without quote");
`endif

endmodule

FILE: hw/rtl/ccs_queue.sv
module ccs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ccs_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       kept_byte,
  output logic             last_of_run
);

  logic [7:0]               q_byte [ccs_pkg::QDepth];
  logic                     q_last [ccs_pkg::QDepth];
  logic [ccs_pkg::QPtrW-1:0] wr_ptr;
  logic [ccs_pkg::QPtrW-1:0] wr_ptr_next;
  logic [ccs_pkg::QPtrW-1:0] wr_ptr_inc;
  logic [ccs_pkg::QPtrW-1:0] rd_ptr;
  logic [ccs_pkg::QCntW-1:0] count;
  logic [ccs_pkg::QCntW-1:0] count_next;
  logic [ccs_pkg::QCntW-1:0] push_n;
  logic                     pop;

  // room for the worst case of two words
  assign room        = count <= ccs_pkg::QCntW'(ccs_pkg::QDepth - 2);
  assign out_valid   = count != '0;
  assign kept_byte   = q_byte[rd_ptr];
  assign last_of_run = q_last[rd_ptr];
  assign pop         = out_valid && !out_stall;
  assign wr_ptr_inc  = wr_ptr + 1'b1;

  always_comb begin
    push_n = '0;
    if (step) begin
      unique case (push.emit)
        ccs_pkg::EMIT_ONE: push_n = ccs_pkg::QCntW'(1);
        ccs_pkg::EMIT_TWO: push_n = ccs_pkg::QCntW'(2);
        default:           push_n = '0;
      endcase
    end
    wr_ptr_next = wr_ptr + push_n[ccs_pkg::QPtrW-1:0];
    count_next  = count + push_n - ccs_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (step) begin
      unique case (push.emit)
        ccs_pkg::EMIT_ONE: begin
          q_byte[wr_ptr] <= push.byte1;
          q_last[wr_ptr] <= 1'b1;
        end
        ccs_pkg::EMIT_TWO: begin
          q_byte[wr_ptr]     <= push.byte0;
          q_last[wr_ptr]     <= 1'b0;
          q_byte[wr_ptr_inc] <= push.byte1;
          q_last[wr_ptr_inc] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    step |-> room)
    else $error("queue written without room");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ccs_pkg::QCntW'(ccs_pkg::QDepth))
    else $error("queue count out of range");
  a_double_push: assert property (@(posedge clk) disable iff (rst)
    step && push.emit == ccs_pkg::EMIT_TWO && !pop |=> count == $past(count) + 2'd2)
    else $error("double push lost a word");
`endif

endmodule

FILE: hw/rtl/c_comment_stripper.sv
// channel | valid     | stall      | payload
// --------+-----------+------------+-------------------------
// input   | in_valid  | in_stall   | text_byte
// output  | out_valid | out_stall  | kept_byte, last_of_run
//
// one source byte is taken per cycle while in_stall is low; its words pass the
// input register, then the result queue, before they show at the output, and a
// queue without room can hold them in the input register
// a byte that releases a held slash gives two words, but the held slash gave
// none, so an output that is never stalled keeps pace at one byte a cycle
// in_stall rises while the input register holds a byte and the queue has
// fewer than two free entries
// synchronous reset returns the scanner to normal mode and empties both stages
module c_comment_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] kept_byte,
  output logic       last_of_run
);

  // input register
  logic           in_full;
  logic [7:0]     in_byte;
  logic           in_take;

  // scanner step and its words
  logic           step;
  logic           room;
  ccs_pkg::push_t push;

  // the held byte moves on once the queue can take two words
  assign step     = in_full && room;
  assign in_stall = in_full && !room;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= text_byte;
    end
  end

  // mode register and the per-byte decision
  ccs_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cur_byte (in_byte),
    .push     (push)
  );

  // result queue, drains one word a cycle while out_stall is low
  ccs_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .push        (push),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kept_byte   (kept_byte),
    .last_of_run (last_of_run)
  );

`ifndef SYNTHESIS
  // a stalled input means a full input register held back by the queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && !room)
    else $error("input stalled without cause");
`endif

endmodule
